### design/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/adtsdf_pkg.sv
// Shared types and constants for the ADTS frame deframer.
// No dependencies; used by the top level and the testbench.
package adtsdf_pkg;

   // Parser modes
   localparam logic [1:0] MODE_HUNT   = 2'd0;
   localparam logic [1:0] MODE_SAW_FF = 2'd1;
   localparam logic [1:0] MODE_FRAME  = 2'd2;

   // Header field constants
   localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
   localparam logic [3:0]  SYNC_NIBBLE = 4'hF;
   localparam logic [12:0] MIN_FRAME   = 13'd7;

   // Frame byte indexes where header fields live
   localparam logic [12:0] POS_PROFILE = 13'd2;
   localparam logic [12:0] POS_LEN_HI  = 13'd3;
   localparam logic [12:0] POS_LEN_MID = 13'd4;
   localparam logic [12:0] POS_LEN_LO  = 13'd5;
   localparam logic [12:0] POS_BODY    = 13'd6;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        frame_first;
      logic        frame_last;
      logic [1:0]  profile_code;
      logic [3:0]  rate_index;
      logic [12:0] frame_length;
      logic        length_error;
   } result_type;

endpackage

### design/adtsdf_byte_if.sv
// Input byte channel: valid/ready handshake carrying one stream byte.
// Depends on nothing.
interface adtsdf_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

### design/adtsdf_frame_if.sv
// Result channel: valid/ready handshake carrying one frame byte with header fields.
// Depends on nothing.
interface adtsdf_frame_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_byte;
   logic        frame_first;
   logic        frame_last;
   logic [1:0]  profile_code;
   logic [3:0]  rate_index;
   logic [12:0] frame_length;
   logic        length_error;

   modport source (output valid, output frame_byte, output frame_first, output frame_last,
                   output profile_code, output rate_index, output frame_length,
                   output length_error, input ready);
   modport sink   (input valid, input frame_byte, input frame_first, input frame_last,
                   input profile_code, input rate_index, input frame_length,
                   input length_error, output ready);
endinterface

### design/adts_frame_deframer_top.sv
// ADTS deframer: one byte per clock in while the 4-entry result queue has room; each
// frame byte enters it when accepted and leaves from its head. A sync 0xFF is held
// until the next byte confirms it, then both are queued together. Sustained rate is
// one byte per clock with the receiver ready, set by the single write-two/read-one
// queue. Synchronous active-high reset returns the parser to hunting and empties it.
// Depends on adtsdf_pkg, adtsdf_byte_if, adtsdf_frame_if and assert_macros.svh.
`include "assert_macros.svh"

module adts_frame_deframer_top (
   input logic           clock,
   input logic           reset,
   adtsdf_byte_if.sink   req,
   adtsdf_frame_if.source rsp
);

   // Parser state
   logic [1:0]  mode_ff, mode_in;
   logic [12:0] pos_ff, pos_in;
   logic [12:0] len_ff, len_in;
   logic [1:0]  prof_ff, prof_in;
   logic [3:0]  rate_ff, rate_in;
   logic        err_ff, err_in;

   // Result queue
   adtsdf_pkg::result_type queue_ff [adtsdf_pkg::QUEUE_DEPTH];
   logic [adtsdf_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [adtsdf_pkg::QCNT_W-1:0] fill_ff, fill_in;

   logic                   req_take;
   logic                   rsp_take;
   logic [1:0]             push_cnt;
   adtsdf_pkg::result_type ent0, ent1;
   logic [7:0]             b;
   logic [13:0]            pos_next;
   logic [12:0]            span;
   logic                   last;

   assign b        = req.stream_byte;
   assign req.ready = (fill_ff <= adtsdf_pkg::QCNT_W'(adtsdf_pkg::QUEUE_DEPTH - 2));
   assign req_take = req.valid && req.ready;
   assign rsp_take = rsp.valid && rsp.ready;
   assign pos_next = {1'b0, pos_ff} + 14'd1;

   // Sync hunt, header capture and frame end detection
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      prof_in  = prof_ff;
      rate_in  = rate_ff;
      err_in   = err_ff;
      push_cnt = 2'd0;
      span     = adtsdf_pkg::MIN_FRAME;
      last     = 1'b0;
      ent0     = '0;
      ent1     = '0;
      case (mode_ff)
         adtsdf_pkg::MODE_SAW_FF: begin
            if (b[7:4] == adtsdf_pkg::SYNC_NIBBLE) begin
               len_in   = '0;
               prof_in  = '0;
               rate_in  = '0;
               err_in   = 1'b0;
               pos_in   = adtsdf_pkg::POS_PROFILE;
               mode_in  = adtsdf_pkg::MODE_FRAME;
               push_cnt = 2'd2;
               ent0.frame_byte  = adtsdf_pkg::SYNC_BYTE;
               ent0.frame_first = 1'b1;
               ent1.frame_byte  = b;
            end else begin
               mode_in = adtsdf_pkg::MODE_HUNT;
            end
         end
         adtsdf_pkg::MODE_FRAME: begin
            if (pos_ff == adtsdf_pkg::POS_PROFILE) begin
               prof_in = b[7:6];
               rate_in = b[5:2];
            end else if (pos_ff == adtsdf_pkg::POS_LEN_HI) begin
               len_in = {b[1:0], 11'd0};
            end else if (pos_ff == adtsdf_pkg::POS_LEN_MID) begin
               len_in = len_ff | {2'd0, b, 3'd0};
            end else if (pos_ff == adtsdf_pkg::POS_LEN_LO) begin
               len_in = len_ff | {10'd0, b[7:5]};
               err_in = ((len_ff | {10'd0, b[7:5]}) < adtsdf_pkg::MIN_FRAME);
            end
            span = err_in ? adtsdf_pkg::MIN_FRAME : len_in;
            last = (pos_ff >= adtsdf_pkg::POS_BODY) && (pos_next >= {1'b0, span});
            push_cnt = 2'd1;
            ent0.frame_byte   = b;
            ent0.frame_last   = last;
            ent0.profile_code = prof_in;
            ent0.rate_index   = rate_in;
            if (pos_ff >= adtsdf_pkg::POS_LEN_LO) begin
               ent0.frame_length = len_in;
               ent0.length_error = err_in;
            end
            if (last) begin
               mode_in = adtsdf_pkg::MODE_HUNT;
               pos_in  = '0;
            end else begin
               pos_in = pos_next[12:0];
            end
         end
         default: begin
            mode_in = (b == adtsdf_pkg::SYNC_BYTE) ? adtsdf_pkg::MODE_SAW_FF
                                                   : adtsdf_pkg::MODE_HUNT;
         end
      endcase
      if (!req_take) begin
         push_cnt = 2'd0;
      end
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= adtsdf_pkg::MODE_HUNT;
         pos_ff  <= '0;
         len_ff  <= '0;
         prof_ff <= '0;
         rate_ff <= '0;
         err_ff  <= 1'b0;
      end else if (req_take) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         prof_ff <= prof_in;
         rate_ff <= rate_in;
         err_ff  <= err_in;
      end
   end

   // Queue storage, up to two writes per request
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= ent0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + adtsdf_pkg::QPTR_W'(1)] <= ent1;
      end
   end

   // Queue pointers and fill count
   assign fill_in = fill_ff + adtsdf_pkg::QCNT_W'(push_cnt)
                    - adtsdf_pkg::QCNT_W'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + adtsdf_pkg::QPTR_W'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + adtsdf_pkg::QPTR_W'(rsp_take);
         fill_ff   <= fill_in;
      end
   end

   // Result outputs from queue head
   assign rsp.valid        = (fill_ff != '0);
   assign rsp.frame_byte   = queue_ff[rd_ptr_ff].frame_byte;
   assign rsp.frame_first  = queue_ff[rd_ptr_ff].frame_first;
   assign rsp.frame_last   = queue_ff[rd_ptr_ff].frame_last;
   assign rsp.profile_code = queue_ff[rd_ptr_ff].profile_code;
   assign rsp.rate_index   = queue_ff[rd_ptr_ff].rate_index;
   assign rsp.frame_length = queue_ff[rd_ptr_ff].frame_length;
   assign rsp.length_error = queue_ff[rd_ptr_ff].length_error;

   // Checks
   `CHK_IMPL(a_fill_bound, clock, reset, 1'b1,
             fill_ff <= adtsdf_pkg::QCNT_W'(adtsdf_pkg::QUEUE_DEPTH), "queue overfilled")
   `CHK_IMPL(a_frame_pos, clock, reset, mode_ff == adtsdf_pkg::MODE_FRAME,
             pos_ff >= adtsdf_pkg::POS_PROFILE, "frame position below header byte 2")
   `CHK_NEXT(a_sync_enter, clock, reset,
             req_take && mode_ff == adtsdf_pkg::MODE_SAW_FF && b[7:4] == adtsdf_pkg::SYNC_NIBBLE,
             mode_ff == adtsdf_pkg::MODE_FRAME && pos_ff == adtsdf_pkg::POS_PROFILE,
             "sync did not open a frame")
   `CHK_IMPL(a_no_room, clock, reset,
             fill_ff > adtsdf_pkg::QCNT_W'(adtsdf_pkg::QUEUE_DEPTH - 2), !req.ready,
             "request taken without room for two results")

endmodule

### tb/testbench.sv
// Testbench for adts_frame_deframer_top: drives ADTS byte requests with random pacing
// and checks every frame byte against an in-bench parser model, field by field.
// Depends on adtsdf_pkg, adtsdf_byte_if, adtsdf_frame_if and the deframer RTL.
module testbench;

   localparam int CYCLE_LIMIT  = 8_000_000;
   localparam int RANDOM_BYTES = 1150;
   localparam int REPORT_MAX   = 10;

   logic clock;
   logic reset;

   adtsdf_byte_if  req_if ();
   adtsdf_frame_if rsp_if ();

   adts_frame_deframer_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // Frame bytes predicted but not yet seen on the result channel
   adtsdf_pkg::result_type pending_frame_bytes[$];

   int mismatches = 0;
   int cycle_count = 0;

   // Pacing controls shared by the test tasks and the receiver
   bit sender_quiet = 1'b0;
   bit rsp_quiet    = 1'b0;
   int long_hold    = 0;

   // Parser model state
   logic [1:0]  scan_mode   = adtsdf_pkg::MODE_HUNT;
   logic [12:0] scan_pos    = '0;
   logic [12:0] hdr_length  = '0;
   logic [1:0]  hdr_profile = '0;
   logic [3:0]  hdr_rate    = '0;
   logic        hdr_error   = 1'b0;

   // Clock and the single reset pulse
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
   end

   // Mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // One frame byte as the block should present it at a given frame position
   function automatic adtsdf_pkg::result_type frame_result(logic [7:0] b, logic [12:0] pos,
                                                           logic last);
      adtsdf_pkg::result_type r;
      r.frame_byte   = b;
      r.frame_first  = (pos == 13'd0);
      r.frame_last   = last;
      r.profile_code = (pos >= adtsdf_pkg::POS_PROFILE) ? hdr_profile : 2'd0;
      r.rate_index   = (pos >= adtsdf_pkg::POS_PROFILE) ? hdr_rate : 4'd0;
      r.frame_length = (pos >= adtsdf_pkg::POS_LEN_LO) ? hdr_length : 13'd0;
      r.length_error = (pos >= adtsdf_pkg::POS_LEN_LO) ? hdr_error : 1'b0;
      return r;
   endfunction

   // Parser model: advance on one accepted byte, queue the frame bytes it releases
   task automatic follow_stream(input logic [7:0] b);
      logic [12:0] pos;
      logic [12:0] span;
      logic        last;
      case (scan_mode)
         adtsdf_pkg::MODE_SAW_FF: begin
            if (b[7:4] == adtsdf_pkg::SYNC_NIBBLE) begin
               hdr_length  = '0;
               hdr_profile = '0;
               hdr_rate    = '0;
               hdr_error   = 1'b0;
               pending_frame_bytes.push_back(frame_result(adtsdf_pkg::SYNC_BYTE, 13'd0,
                                                          1'b0));
               pending_frame_bytes.push_back(frame_result(b, 13'd1, 1'b0));
               scan_pos  = adtsdf_pkg::POS_PROFILE;
               scan_mode = adtsdf_pkg::MODE_FRAME;
            end else begin
               scan_mode = adtsdf_pkg::MODE_HUNT;
            end
         end
         adtsdf_pkg::MODE_FRAME: begin
            pos = scan_pos;
            // header fields; frame bytes are never tested for sync
            if (pos == adtsdf_pkg::POS_PROFILE) begin
               hdr_profile = b[7:6];
               hdr_rate    = b[5:2];
            end else if (pos == adtsdf_pkg::POS_LEN_HI) begin
               hdr_length = {b[1:0], 11'd0};
            end else if (pos == adtsdf_pkg::POS_LEN_MID) begin
               hdr_length[10:3] = b;
            end else if (pos == adtsdf_pkg::POS_LEN_LO) begin
               hdr_length[2:0] = b[7:5];
               hdr_error = (hdr_length < adtsdf_pkg::MIN_FRAME);
            end
            last = 1'b0;
            if (pos >= adtsdf_pkg::POS_BODY) begin
               span = hdr_error ? adtsdf_pkg::MIN_FRAME : hdr_length;
               last = (int'(pos) + 1 >= int'(span));
            end
            pending_frame_bytes.push_back(frame_result(b, pos, last));
            if (last) begin
               scan_mode = adtsdf_pkg::MODE_HUNT;
               scan_pos  = '0;
            end else begin
               scan_pos = pos + 13'd1;
            end
         end
         default: begin
            scan_mode = (b == adtsdf_pkg::SYNC_BYTE) ? adtsdf_pkg::MODE_SAW_FF
                                                     : adtsdf_pkg::MODE_HUNT;
         end
      endcase
   endtask

   // Send one byte request; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.stream_byte <= b;
      do
         @(posedge clock);
      while (!req_if.ready);
      follow_stream(b);
      @(negedge clock);
   endtask

   // Complete ADTS frame: header built from the given fields, random body
   task automatic send_frame(input logic [3:0] sync_lo, input logic [7:0] hdr2,
                             input logic [12:0] hdr_len, input logic [5:0] spare3,
                             input logic [4:0] spare5);
      int total;
      total = (hdr_len < adtsdf_pkg::MIN_FRAME) ? int'(adtsdf_pkg::MIN_FRAME)
                                                : int'(hdr_len);
      send_byte(adtsdf_pkg::SYNC_BYTE);
      send_byte({adtsdf_pkg::SYNC_NIBBLE, sync_lo});
      send_byte(hdr2);
      send_byte({spare3, hdr_len[12:11]});
      send_byte(hdr_len[10:3]);
      send_byte({hdr_len[2:0], spare5});
      // body carries stray sync bytes now and then
      for (int i = 6; i < total; i++)
         send_byte(($urandom_range(0, 7) == 0) ? adtsdf_pkg::SYNC_BYTE
                                               : 8'($urandom_range(0, 255)));
   endtask

   // Sender stops until every predicted frame byte has come out
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_frame_bytes.size() != 0);
   endtask

   // Noise and false syncs only: nothing may come out
   task automatic test_hunting();
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(adtsdf_pkg::SYNC_BYTE);
      send_byte(8'h3A);
      send_byte(adtsdf_pkg::SYNC_BYTE);
      send_byte(8'hEF);
      send_byte(8'h80);
      wait_drained();
   endtask

   // Header lengths 6 and 0: error flag, frame cut after seven bytes
   task automatic test_short_length();
      send_frame(4'h1, 8'h50, 13'd6, 6'h20, 5'h00);
      send_frame(4'h0, 8'h00, 13'd0, 6'h00, 5'h00);
      wait_drained();
   endtask

   // Length exactly 7, all other header bits high, sync as FF FF
   task automatic test_shortest_frame();
      send_frame(4'hF, 8'hFF, 13'd7, 6'h3F, 5'h1F);
      wait_drained();
   endtask

   // Receiver holds off while the sender streams frames back to back
   task automatic test_backpressure();
      sender_quiet = 1'b1;
      long_hold = 200;
      repeat (3)
         send_frame(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                    13'($urandom_range(12, 30)), 6'($urandom_range(0, 63)),
                    5'($urandom_range(0, 31)));
      sender_quiet = 1'b0;
      wait_drained();
   endtask

   // Long frame, alternating length bits, spare header bits high
   task automatic test_long_frame();
      send_frame(4'hF, 8'hFF, 13'h155, 6'h3F, 5'h1F);
      wait_drained();
   endtask

   // Mostly well-formed frames with random content, some short-length frames, noise and false syncs
   task automatic test_random_stream();
      int frame_bytes_sent;
      int pick;
      int len;
      frame_bytes_sent = 0;
      while (frame_bytes_sent < RANDOM_BYTES) begin
         sender_quiet = ($urandom_range(0, 5) == 0);
         rsp_quiet    = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = ($urandom_range(0, 40) == 0) ? $urandom_range(49, 600)
                                                : $urandom_range(7, 48);
            send_frame(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 13'(len),
                       6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)));
            frame_bytes_sent += len;
         end else if (pick < 82) begin
            send_frame(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                       13'($urandom_range(0, 6)), 6'($urandom_range(0, 63)),
                       5'($urandom_range(0, 31)));
            frame_bytes_sent += 7;
         end else if (pick < 92) begin
            // noise without sync bytes
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(0, 254)));
         end else begin
            send_byte(adtsdf_pkg::SYNC_BYTE);
            send_byte(8'($urandom_range(0, 8'hEF)));
         end
      end
      sender_quiet = 1'b0;
      rsp_quiet    = 1'b0;
      wait_drained();
   endtask

   // Receiver pacing: random gaps, quiet stretches, long holds on request
   initial begin : rsp_pacing
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            hold_left = long_hold;
            long_hold = 0;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (rsp_quiet) begin
            rsp_if.ready <= 1'b1;
         end else begin
            hold_left = pick_gap();
            rsp_if.ready <= (hold_left == 0);
            if (hold_left > 0)
               hold_left--;
         end
      end
   end

   function automatic string show(adtsdf_pkg::result_type r);
      return $sformatf("byte %h first %b last %b profile %0d rate %0d length %0d err %b",
                       r.frame_byte, r.frame_first, r.frame_last, r.profile_code,
                       r.rate_index, r.frame_length, r.length_error);
   endfunction

   // Compare each delivered frame byte with the oldest prediction
   always @(posedge clock) begin : frame_check
      adtsdf_pkg::result_type got;
      adtsdf_pkg::result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         got.frame_byte   = rsp_if.frame_byte;
         got.frame_first  = rsp_if.frame_first;
         got.frame_last   = rsp_if.frame_last;
         got.profile_code = rsp_if.profile_code;
         got.rate_index   = rsp_if.rate_index;
         got.frame_length = rsp_if.frame_length;
         got.length_error = rsp_if.length_error;
         if (pending_frame_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("cycle %0d: unexpected frame byte: %s", cycle_count, show(got));
         end else begin
            want = pending_frame_bytes.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("cycle %0d: expected %s", cycle_count, show(want));
                  $display("cycle %0d: actual   %s", cycle_count, show(got));
               end
            end
         end
      end
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Test sequence
   initial begin
      req_if.valid = 1'b0;
      req_if.stream_byte = 8'h00;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      test_hunting();
      test_short_length();
      test_shortest_frame();
      test_backpressure();
      test_random_stream();
      test_long_frame();
      wait_drained();
      repeat (10) @(negedge clock);
      if (pending_frame_bytes.size() != 0)
         $display("%0d predicted frame bytes never arrived", pending_frame_bytes.size());
      if (mismatches == 0 && pending_frame_bytes.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

### adts_frame_deframer_top.f
+incdir+design
design/adtsdf_pkg.sv
design/adtsdf_byte_if.sv
design/adtsdf_frame_if.sv
design/adts_frame_deframer_top.sv
tb/testbench.sv
